[design/qvr_pkg.sv]
// Types and constants shared by the quaternion vector rotate pipeline.
package qvr_pkg;

  localparam int VEC_W  = 32;
  localparam int QUAT_W = 16;
  localparam int PROD_W = 2 * QUAT_W;
  localparam int TERM_W = 35;
  localparam int HALF_W = VEC_W / 2;
  localparam int PH_W   = HALF_W + TERM_W;
  localparam int PL_W   = HALF_W + 1 + TERM_W;
  localparam int HS_W   = PH_W + 2;
  localparam int LS_W   = PL_W + 2;
  localparam int ACC_W  = 70;
  localparam int FRAC_W = 30;
  localparam int RES_W  = ACC_W - FRAC_W;

  localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(1) <<< FRAC_W;
  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [VEC_W-1:0]  SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0]  SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [VEC_W-1:0]  vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_term;
  } mat_en_t;

  typedef struct packed {
    logic ld_part;
    logic ld_sum;
    logic ld_res;
  } dot_en_t;

endpackage

[design/qvr_matrix.sv]
// Quaternion products and rotation matrix terms, two register stages.
module qvr_matrix (
  input  logic                                   clk,
  input  qvr_pkg::mat_en_t                       en,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      qx,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      qy,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      qz,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      qw,
  output qvr_pkg::term_t                         mat_o [0:2][0:2]
);

  logic signed [qvr_pkg::PROD_W-1:0] wx_r, wy_r, wz_r, xx_r, xy_r, xz_r, yy_r, yz_r, zz_r;
  qvr_pkg::term_t                    term_r [0:2][0:2];

  // products of the undoubled components; doubling happens in the term stage
  always_ff @(posedge clk) begin
    if (en.ld_prod) begin
      wx_r <= qw * qx;
      wy_r <= qw * qy;
      wz_r <= qw * qz;
      xx_r <= qx * qx;
      xy_r <= qx * qy;
      xz_r <= qx * qz;
      yy_r <= qy * qy;
      yz_r <= qy * qz;
      zz_r <= qz * qz;
    end
  end

  function automatic qvr_pkg::term_t dbl(input logic signed [qvr_pkg::PROD_W-1:0] p);
    qvr_pkg::term_t t;
    t = qvr_pkg::TERM_W'(p);
    return t <<< 1;
  endfunction

  always_ff @(posedge clk) begin
    if (en.ld_term) begin
      term_r[0][0] <= qvr_pkg::ONE_Q30 - dbl(yy_r) - dbl(zz_r);
      term_r[0][1] <= dbl(xy_r) - dbl(wz_r);
      term_r[0][2] <= dbl(xz_r) + dbl(wy_r);
      term_r[1][0] <= dbl(xy_r) + dbl(wz_r);
      term_r[1][1] <= qvr_pkg::ONE_Q30 - dbl(xx_r) - dbl(zz_r);
      term_r[1][2] <= dbl(yz_r) - dbl(wx_r);
      term_r[2][0] <= dbl(xz_r) - dbl(wy_r);
      term_r[2][1] <= dbl(yz_r) + dbl(wx_r);
      term_r[2][2] <= qvr_pkg::ONE_Q30 - dbl(xx_r) - dbl(yy_r);
    end
  end

  assign mat_o = term_r;

endmodule

[design/qvr_dot.sv]
// One matrix row times the vector: split products, sums, rounding and saturation.
module qvr_dot (
  input  logic                             clk,
  input  qvr_pkg::dot_en_t                 en,
  input  qvr_pkg::vec_t                    vec_i  [0:2],
  input  qvr_pkg::term_t                   term_i [0:2],
  output logic signed [qvr_pkg::VEC_W-1:0] rot_o,
  output logic                             clip_o
);

  logic signed [qvr_pkg::PH_W-1:0]  ph_r [0:2];
  logic signed [qvr_pkg::PL_W-1:0]  pl_r [0:2];
  logic signed [qvr_pkg::HS_W-1:0]  hs_r;
  logic signed [qvr_pkg::LS_W-1:0]  ls_r;
  logic signed [qvr_pkg::VEC_W-1:0] rot_r, rot_nxt;
  logic                             clip_r, clip_nxt;
  logic signed [qvr_pkg::ACC_W-1:0] acc;
  logic signed [qvr_pkg::RES_W-1:0] res;
  logic [qvr_pkg::RES_W-qvr_pkg::VEC_W:0] top_bits;

  // split each vector component into a signed high and unsigned low half
  always_ff @(posedge clk) begin
    if (en.ld_part) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= $signed(vec_i[i][qvr_pkg::VEC_W-1:qvr_pkg::HALF_W]) * term_i[i];
        pl_r[i] <= $signed({1'b0, vec_i[i][qvr_pkg::HALF_W-1:0]}) * term_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_sum) begin
      hs_r <= qvr_pkg::HS_W'(ph_r[0]) + qvr_pkg::HS_W'(ph_r[1]) + qvr_pkg::HS_W'(ph_r[2]);
      ls_r <= qvr_pkg::LS_W'(pl_r[0]) + qvr_pkg::LS_W'(pl_r[1]) + qvr_pkg::LS_W'(pl_r[2]);
    end
  end

  always_comb begin
    acc      = (qvr_pkg::ACC_W'(hs_r) <<< qvr_pkg::HALF_W) + qvr_pkg::ACC_W'(ls_r)
               + qvr_pkg::RND_HALF;
    res      = acc[qvr_pkg::ACC_W-1:qvr_pkg::FRAC_W];
    top_bits = res[qvr_pkg::RES_W-1:qvr_pkg::VEC_W-1];
    clip_nxt = !((&top_bits) || !(|top_bits));
    if (clip_nxt) begin
      rot_nxt = res[qvr_pkg::RES_W-1] ? qvr_pkg::SAT_MIN : qvr_pkg::SAT_MAX;
    end else begin
      rot_nxt = res[qvr_pkg::VEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_res) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign rot_o  = rot_r;
  assign clip_o = clip_r;

endmodule

[design/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotate pipeline.
//
//   port group   dir   handshake           payload
//   in_          in    in_valid/in_stall   in_word  (vector Q16.16, quaternion Q1.15)
//   out_         out   out_valid/out_stall out_word (rotated vector Q16.16, saturated)
//
// Five register stages: quaternion products, matrix terms, split vector*term
// products, row sums, rounding with saturation (the output register).
// One word enters per cycle when nothing stalls.
// Reset clears the stage valid bits only.
// Each stage loads when it is empty or the next stage moves, so bubbles close
// up under out_stall and in_stall rises only when every stage holds a word.
module quaternion_vector_rotate (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qvr_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output qvr_pkg::out_t out_word
);

  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic v_a_nxt, v_b_nxt, v_c_nxt, v_d_nxt, v_e_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  qvr_pkg::vec_t    vec_a_r [0:2];
  qvr_pkg::vec_t    vec_b_r [0:2];
  qvr_pkg::term_t   mat [0:2][0:2];
  qvr_pkg::mat_en_t mat_en;
  qvr_pkg::dot_en_t dot_en;
  logic signed [qvr_pkg::VEC_W-1:0] rot [0:2];
  logic [2:0]                       clip;

  assign rdy_e = !v_e_r || !out_stall;
  assign rdy_d = !v_d_r || rdy_e;
  assign rdy_c = !v_c_r || rdy_d;
  assign rdy_b = !v_b_r || rdy_c;
  assign rdy_a = !v_a_r || rdy_b;

  assign in_stall = !rdy_a;

  always_comb begin
    v_a_nxt = rdy_a ? in_valid : v_a_r;
    v_b_nxt = rdy_b ? v_a_r : v_b_r;
    v_c_nxt = rdy_c ? v_b_r : v_c_r;
    v_d_nxt = rdy_d ? v_c_r : v_d_r;
    v_e_nxt = rdy_e ? v_d_r : v_e_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
      v_d_r <= v_d_nxt;
      v_e_r <= v_e_nxt;
    end
  end

  // carry the vector alongside the matrix stages
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      vec_a_r[0] <= in_word.vec_x;
      vec_a_r[1] <= in_word.vec_y;
      vec_a_r[2] <= in_word.vec_z;
    end
    if (rdy_b) begin
      vec_b_r <= vec_a_r;
    end
  end

  assign mat_en.ld_prod = rdy_a;
  assign mat_en.ld_term = rdy_b;
  assign dot_en.ld_part = rdy_c;
  assign dot_en.ld_sum  = rdy_d;
  assign dot_en.ld_res  = rdy_e;

  qvr_matrix u_matrix (
    .clk   (clk),
    .en    (mat_en),
    .qx    (in_word.quat_x),
    .qy    (in_word.quat_y),
    .qz    (in_word.quat_z),
    .qw    (in_word.quat_w),
    .mat_o (mat)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    qvr_dot u_dot (
      .clk    (clk),
      .en     (dot_en),
      .vec_i  (vec_b_r),
      .term_i (mat[r]),
      .rot_o  (rot[r]),
      .clip_o (clip[r])
    );
  end

  assign out_valid          = v_e_r;
  assign out_word.rot_x     = rot[0];
  assign out_word.rot_y     = rot[1];
  assign out_word.rot_z     = rot[2];
  assign out_word.saturated = |clip;

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_a_r)
    else $error("accepted word did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_a_r && v_b_r && v_c_r && v_d_r && v_e_r && out_stall |-> in_stall)
    else $error("input taken while every stage is full and the output stalls");

  a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v_b_r && !v_c_r |=> v_c_r)
    else $error("word failed to advance into an empty stage");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.saturated |->
      out_word.rot_x == qvr_pkg::SAT_MAX || out_word.rot_x == qvr_pkg::SAT_MIN ||
      out_word.rot_y == qvr_pkg::SAT_MAX || out_word.rot_y == qvr_pkg::SAT_MIN ||
      out_word.rot_z == qvr_pkg::SAT_MAX || out_word.rot_z == qvr_pkg::SAT_MIN)
    else $error("saturated flag without a clipped component");

endmodule

[sim/testbench.sv]
// Self-checking testbench for quaternion_vector_rotate: directed table plus random words.
module testbench;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    qvr_pkg::in_t  word;
    bit            known;
    qvr_pkg::out_t rot;
  } stim_t;

  localparam int     N_RANDOM    = 800;
  localparam int     HOLD_CYCLES = 64;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     MAX_PRINTS  = 20;
  localparam longint UNIT_Q30    = 64'sd1 << 30;
  localparam longint ROUND_HALF  = 64'sd1 << 29;
  localparam longint Q16_MAX     = 64'sd2147483647;
  localparam longint Q16_MIN     = -64'sd2147483648;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  qvr_pkg::in_t  in_word;
  logic          out_valid;
  logic          out_stall;
  qvr_pkg::out_t out_word;

  qvr_pkg::out_t pending_rot [$];
  int   words_in;
  int   words_out = 0;
  int   sat_seen = 0;
  int   stall_cycles = 0;
  int   errors = 0;
  int   cycles = 0;
  bit   quiet;
  bit   hold_go;

  logic [15:0] q_edge [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};

  stim_t dir_tab [0:13] = '{
    '{'{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{'{32'h7fffffff, 32'h80000000, 32'h00000001, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h7fffffff, 32'h80000000, 32'h00000001, 1'b0}},
    '{'{32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0}},
    '{'{32'h00000001, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h00000001, 32'h7fffffff, 32'h80000001, 1'b1}},
    '{'{32'h00010000, 32'h00030000, 32'h80000000, 16'h0, 16'h8000, 16'h0, 16'h0}, 1'b1,
      '{32'hffff0000, 32'h00030000, 32'h7fffffff, 1'b1}},
    '{'{32'h80000000, 32'h00000005, 32'h12345678, 16'h0, 16'h0, 16'h8000, 16'h0}, 1'b1,
      '{32'h7fffffff, 32'hfffffffb, 32'h12345678, 1'b1}},
    '{'{32'h7fffffff, 32'h80000000, 32'h0000abcd, 16'h0, 16'h0, 16'h0, 16'h8000}, 1'b1,
      '{32'h7fffffff, 32'h80000000, 32'h0000abcd, 1'b0}},
    '{'{32'h00010000, 32'h00020000, 32'hfffd0000, 16'h0, 16'h0, 16'h0, 16'h7fff}, 1'b0,
      '0},
    '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
      1'b0, '0},
    '{'{32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
      1'b0, '0},
    '{'{32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h5a82, 16'h5a82}, 1'b0, '0},
    '{'{32'h00000001, 32'h00000003, 32'hffffffff, 16'h0, 16'h0, 16'h4000, 16'h4000}, 1'b0,
      '0},
    '{'{32'h55555555, 32'haaaaaaaa, 32'h55555555, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
      1'b0, '0},
    '{'{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555},
      1'b0, '0}
  };

  quaternion_vector_rotate DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  function automatic qvr_pkg::out_t rotate_vector(qvr_pkg::in_t w);
    longint qx, qy, qz, qw;
    longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
    longint mat [3][3];
    wide_t  vec [3];
    wide_t  acc;
    qvr_pkg::vec_t res [3];
    qvr_pkg::out_t r;
    qx = $signed(w.quat_x);
    qy = $signed(w.quat_y);
    qz = $signed(w.quat_z);
    qw = $signed(w.quat_w);
    xx = 2 * qx * qx; xy = 2 * qx * qy; xz = 2 * qx * qz;
    yy = 2 * qy * qy; yz = 2 * qy * qz; zz = 2 * qz * qz;
    wx = 2 * qw * qx; wy = 2 * qw * qy; wz = 2 * qw * qz;
    mat[0][0] = UNIT_Q30 - yy - zz; mat[0][1] = xy - wz; mat[0][2] = xz + wy;
    mat[1][0] = xy + wz; mat[1][1] = UNIT_Q30 - xx - zz; mat[1][2] = yz - wx;
    mat[2][0] = xz - wy; mat[2][1] = yz + wx; mat[2][2] = UNIT_Q30 - xx - yy;
    vec[0] = $signed(w.vec_x);
    vec[1] = $signed(w.vec_y);
    vec[2] = $signed(w.vec_z);
    r.saturated = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        acc = acc + vec[i] * wide_t'(mat[row][i]);
      end
      acc = (acc + ROUND_HALF) >>> 30;
      if (acc > Q16_MAX) begin
        res[row] = 32'h7fffffff;
        r.saturated = 1'b1;
      end else if (acc < Q16_MIN) begin
        res[row] = 32'h80000000;
        r.saturated = 1'b1;
      end else begin
        res[row] = acc[31:0];
      end
    end
    r.rot_x = res[0];
    r.rot_y = res[1];
    r.rot_z = res[2];
    return r;
  endfunction

  function automatic logic [31:0] small_q16();
    logic [31:0] r;
    r = $urandom;
    return {{11{r[20]}}, r[20:0]};
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch %s on word %0d: got %h want %h", field, words_out, got, want);
  endtask

  task automatic send_word(input qvr_pkg::in_t w, input qvr_pkg::out_t want);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall);
    pending_rot.push_back(want);
    words_in++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_rot.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall)
      stall_cycles <= stall_cycles + 1;
  end

  always @(posedge clk) begin : check_rot
    qvr_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (pending_rot.size() == 0) begin
        report("unexpected word", out_word.rot_x, 32'h0);
      end else begin
        want = pending_rot.pop_front();
        if (want.saturated)
          sat_seen++;
        if (out_word.rot_x !== want.rot_x)
          report("rot_x", out_word.rot_x, want.rot_x);
        if (out_word.rot_y !== want.rot_y)
          report("rot_y", out_word.rot_y, want.rot_y);
        if (out_word.rot_z !== want.rot_z)
          report("rot_z", out_word.rot_z, want.rot_z);
        if (out_word.saturated !== want.saturated)
          report("saturated", 32'(out_word.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin : receiver
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = rst_n && !quiet && ($urandom_range(99) < 25);
    end
  end

  initial begin : stimulus
    qvr_pkg::in_t w;
    int  mode;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    quiet        = 1'b0;
    hold_go      = 1'b0;
    words_in     = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      send_word(dir_tab[k].word,
                dir_tab[k].known ? dir_tab[k].rot : rotate_vector(dir_tab[k].word));
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= 150 && k < 350);
      if (k == 450)
        hold_go = 1'b1;
      mode = $urandom_range(9);
      w = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if (mode >= 3 && mode <= 5) begin
        w.vec_x = small_q16();
        w.vec_y = small_q16();
        w.vec_z = small_q16();
      end else if (mode == 6 || mode == 7) begin
        w.quat_x = q_edge[$urandom_range(4)];
        w.quat_w = q_edge[$urandom_range(4)];
      end else if (mode >= 8) begin
        w.quat_w = $urandom_range(1) ? 16'h7000 + 16'($urandom_range(4095))
                                     : 16'h8000 + 16'($urandom_range(4095));
        w.quat_x = {{6{w.quat_x[9]}}, w.quat_x[9:0]};
        w.quat_y = {{6{w.quat_y[9]}}, w.quat_y[9:0]};
        w.quat_z = {{6{w.quat_z[9]}}, w.quat_z[9:0]};
        w.vec_x  = small_q16();
      end
      send_word(w, rotate_vector(w));
    end
    in_valid = 1'b0;

    while (pending_rot.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d words in, %0d rotated words out, %0d of them clipped",
             words_in, words_out, sat_seen);
    $display("input held off for %0d cycles under output back-pressure", stall_cycles);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
